### hdl/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and defaults for the counting semaphore bank.
// ----------------------------------------------------------------------------
package csb_pkg;

    localparam int NUM_SEMS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int COUNT_BITS_DEF  = 16;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_INIT   = 2'd0,
        FUNC_WAIT   = 2'd1,
        FUNC_SIGNAL = 2'd2
    } t_func;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  sem_index;
        logic [15:0] init_value;
        logic [7:0]  process_id;
    } t_cmd;

    typedef struct packed {
        logic [15:0] count_after;
        logic [3:0]  waiters_after;
        logic        blocked;
        logic        woken_valid;
        logic [7:0]  woken_process;
        logic        queue_overflow;
    } t_result;

endpackage

### hdl/csb_ram.sv
// ----------------------------------------------------------------------------
// csb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/csb_core.sv
// ----------------------------------------------------------------------------
// csb_core
// Per-semaphore state, single-pass update logic and the waiter id store.
// ----------------------------------------------------------------------------
module csb_core
    import csb_pkg::*;
#(
    parameter int NUM_SEMS    = NUM_SEMS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_cmd    i_cmd,
    output t_result o_res,
    output logic [7:0] o_woken_id
);

    localparam int SEM_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = SEM_W + PTR_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic [COUNT_BITS-1:0] r_count [NUM_SEMS];
    logic [PTR_W-1:0]      r_head  [NUM_SEMS];
    logic [PTR_W-1:0]      r_tail  [NUM_SEMS];
    logic [FILL_W-1:0]     r_fill  [NUM_SEMS];

    logic [31:0]           idx_ext;
    logic                  in_rng;
    logic [SEM_W-1:0]      s;
    logic [COUNT_BITS-1:0] cnt_cur, n_count;
    logic [PTR_W-1:0]      head_cur, tail_cur, n_head, n_tail;
    logic [FILL_W-1:0]     fill_cur, n_fill;
    logic                  upd, ram_we;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [31:0]           init_ext, cnt_ext, fill_ext;
    t_result               res;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        logic [31:0] q;
        q = 32'(p) + 32'd1;
        return (q >= 32'(QUEUE_DEPTH)) ? '0 : q[PTR_W-1:0];
    endfunction

    always_comb begin
        idx_ext  = 32'(i_cmd.sem_index);
        in_rng   = idx_ext < 32'(NUM_SEMS);
        s        = idx_ext[SEM_W-1:0];
        cnt_cur  = r_count[s];
        head_cur = r_head[s];
        tail_cur = r_tail[s];
        fill_cur = r_fill[s];
        init_ext = 32'(i_cmd.init_value);

        n_count   = cnt_cur;
        n_head    = head_cur;
        n_tail    = tail_cur;
        n_fill    = fill_cur;
        upd       = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = {s, tail_cur};
        ram_raddr = {s, head_cur};
        res       = '0;

        if (in_rng) begin
            upd = 1'b1;
            case (i_cmd.func)
                FUNC_INIT: begin
                    n_count = (init_ext > 32'(CMAX)) ? CMAX : init_ext[COUNT_BITS-1:0];
                end
                FUNC_WAIT: begin
                    if (cnt_cur != '0) begin
                        n_count = cnt_cur - COUNT_BITS'(1);
                    end else if (32'(fill_cur) >= 32'(QUEUE_DEPTH)) begin
                        res.queue_overflow = 1'b1;
                    end else begin
                        ram_we      = 1'b1;
                        n_tail      = wrap_next(tail_cur);
                        n_fill      = fill_cur + FILL_W'(1);
                        res.blocked = 1'b1;
                    end
                end
                FUNC_SIGNAL: begin
                    if (fill_cur != '0) begin
                        n_head          = wrap_next(head_cur);
                        n_fill          = fill_cur - FILL_W'(1);
                        res.woken_valid = 1'b1;
                    end else if (cnt_cur != CMAX) begin
                        n_count = cnt_cur + COUNT_BITS'(1);
                    end
                end
                default: begin
                end
            endcase
            cnt_ext           = 32'(n_count);
            fill_ext          = 32'(n_fill);
            res.count_after   = cnt_ext[15:0];
            res.waiters_after = fill_ext[3:0];
        end else begin
            cnt_ext  = '0;
            fill_ext = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SEMS; i++) begin
                r_count[i] <= '0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_fill[i]  <= '0;
            end
        end else if (i_vld && upd) begin
            r_count[s] <= n_count;
            r_head[s]  <= n_head;
            r_tail[s]  <= n_tail;
            r_fill[s]  <= n_fill;
        end
    end

    csb_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ids (
        .i_clk   (i_clk),
        .i_we    (i_vld && ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.process_id),
        .i_raddr (ram_raddr),
        .o_rdata (o_woken_id)
    );

    assign o_res = res;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && in_rng) |-> (32'(fill_cur) <= 32'(QUEUE_DEPTH)))
        else $error("queue fill beyond depth");

    a_enq_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && ram_we) |-> (res.blocked && !res.queue_overflow))
        else $error("enqueue without blocked flag");

    a_wake_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && res.woken_valid) |=> (r_count[$past(s)] == $past(cnt_cur)))
        else $error("count changed on wakeup");

    a_wait_takes_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && in_rng && i_cmd.func == FUNC_WAIT && cnt_cur != '0)
        |=> (r_count[$past(s)] == $past(cnt_cur) - COUNT_BITS'(1)))
        else $error("wait did not take a unit");
`endif

endmodule

### hdl/counting_semaphore_bank.sv
// ----------------------------------------------------------------------------
// counting_semaphore_bank
// Bank of counting semaphores with a circular wait queue per semaphore.
// ----------------------------------------------------------------------------
//  channel  | ports                       | transfer when
//  ---------+-----------------------------+---------------------------
//  command  | i_start, o_busy, i_cmd      | i_start high, o_busy low
//  result   | o_done, o_result            | o_done high (one cycle)
//
//  One command per cycle while o_busy is low; its result passes the input
//  register, then the result register and the id store's read register.
//  Reset is synchronous and active low; it clears counts, queue pointers and
//  fill levels. The stored waiter ids are not cleared.
//  o_busy is high during reset and clears once reset is released; the result
//  side cannot stall, so every result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module counting_semaphore_bank
    import csb_pkg::*;
#(
    parameter int NUM_SEMS    = NUM_SEMS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    input  t_cmd    i_cmd,
    output logic    o_done,
    output t_result o_result
);

    // input register
    t_cmd    r_cmd;
    logic    r_cmd_vld;
    // result register; woken id comes from the store's read register
    t_result r_res;
    logic    r_done;
    logic    r_busy;

    t_result core_res;
    logic [7:0] woken_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_cmd_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_cmd_vld <= i_start && !r_busy;
            r_done    <= r_cmd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_cmd <= i_cmd;
        end
        if (r_cmd_vld) begin
            r_res <= core_res;
        end
    end

    csb_core #(
        .NUM_SEMS    (NUM_SEMS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_cmd_vld),
        .i_cmd      (r_cmd),
        .o_res      (core_res),
        .o_woken_id (woken_id)
    );

    always_comb begin
        o_result               = r_res;
        o_result.woken_process = r_res.woken_valid ? woken_id : 8'd0;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

### verif/counting_semaphore_bank_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_bank_tb
// Self-checking bench for the counting semaphore bank. A short table of
// directed commands covers the corner cases: saturation at both ends, a full
// wait queue, wake order, init leaving the queue alone, queue pointer wrap
// and the unused opcode. A long random run follows, steered at a few busy
// semaphores so that their queues fill, drain and wrap. A local model of the
// bank predicts each result not written by hand, and results are checked in order.
// ----------------------------------------------------------------------------
module counting_semaphore_bank_tb;
    import csb_pkg::*;

    localparam int          NSEMS        = NUM_SEMS_DEF;
    localparam int          QDEPTH       = QUEUE_DEPTH_DEF;
    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;     // no-op opcode, reports state
    localparam int          RANDOM_CMDS  = 1400;
    localparam int          DRAIN_CYCLES = 8;        // quiet cycles after the drain
    localparam int          CYCLE_LIMIT  = 100000;

    // ------------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------------
    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_cmd    i_cmd = '0;
    logic    o_busy;
    logic    o_done;
    t_result o_result;

    always #10 i_clk = ~i_clk;

    counting_semaphore_bank dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // ------------------------------------------------------------------------
    // bank model: counts, per-semaphore circular id queues
    // ------------------------------------------------------------------------
    logic [15:0] sem_cnt  [NSEMS];
    logic [7:0]  wait_ids [NSEMS][QDEPTH];
    int          q_head   [NSEMS];
    int          q_tail   [NSEMS];
    int          q_fill   [NSEMS];

    // summary tallies
    int n_cmds, n_queued, n_woken, n_dropped, n_pegged;
    int n_errors;
    int cycle_cnt;

    t_result result_q[$];       // expected results, oldest first

    // Applies one command to the bank model and returns its result.
    function automatic t_result sem_bank_apply(input t_cmd c);
        t_result r;
        int      s;
        r = '0;
        s = int'(c.sem_index);
        case (c.func)
            FUNC_INIT: begin
                sem_cnt[s] = c.init_value;
            end
            FUNC_WAIT: begin
                if (sem_cnt[s] != 16'd0) begin
                    sem_cnt[s] = sem_cnt[s] - 16'd1;
                end else if (q_fill[s] == QDEPTH) begin
                    r.queue_overflow = 1'b1;    // caller dropped, nothing changes
                    n_dropped++;
                end else begin
                    wait_ids[s][q_tail[s]] = c.process_id;
                    q_tail[s] = (q_tail[s] + 1) % QDEPTH;
                    q_fill[s]++;
                    r.blocked = 1'b1;
                    n_queued++;
                end
            end
            FUNC_SIGNAL: begin
                if (q_fill[s] != 0) begin
                    // oldest waiter takes the unit; count is left alone
                    r.woken_valid   = 1'b1;
                    r.woken_process = wait_ids[s][q_head[s]];
                    q_head[s] = (q_head[s] + 1) % QDEPTH;
                    q_fill[s]--;
                    n_woken++;
                end else if (sem_cnt[s] != '1) begin
                    sem_cnt[s] = sem_cnt[s] + 16'd1;
                end else begin
                    n_pegged++;                 // saturated at max
                end
            end
            default: ;                          // unused opcode: report only
        endcase
        r.count_after   = sem_cnt[s];
        r.waiters_after = q_fill[s][3:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------
    typedef struct {
        t_cmd    cmd;
        bit      typed;     // res holds a hand-written expectation
        t_result res;
    } t_row;

    t_row dir_tbl[$];

    function automatic void add_row(input logic [1:0] f, input logic [3:0] idx,
                                    input logic [15:0] val, input logic [7:0] pid,
                                    input bit typed, input logic [15:0] cnt,
                                    input logic [3:0] wtr, input logic blk,
                                    input logic wv, input logic [7:0] wp,
                                    input logic ovf);
        t_row row;
        row.cmd   = '{func: f, sem_index: idx, init_value: val, process_id: pid};
        row.typed = typed;
        row.res   = '{count_after: cnt, waiters_after: wtr, blocked: blk,
                      woken_valid: wv, woken_process: wp, queue_overflow: ovf};
        dir_tbl.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // sender: bursts of back-to-back transfers, random gaps in between
    // ------------------------------------------------------------------------
    int burst_left;

    task automatic issue(input t_cmd c, input bit typed, input t_result typed_res);
        t_result r;
        int      gap;
        i_start <= 1'b1;
        i_cmd   <= c;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        // transfer taken at this edge
        r = sem_bank_apply(c);
        result_q.push_back(typed ? typed_res : r);
        n_cmds++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // random command source; most traffic goes to a small hot set so that
    // queues fill to the brim, overflow, drain and wrap around
    // ------------------------------------------------------------------------
    logic [3:0] hot_sems[3];
    int         wait_bias;      // percent of wait/signal traffic that is wait

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   pick;
        c.process_id = 8'($urandom_range(0, 255));
        c.sem_index  = ($urandom_range(0, 3) != 0) ? hot_sems[$urandom_range(0, 2)]
                                                   : 4'($urandom_range(0, NSEMS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            c.func = FUNC_UNUSED;
        end else if (pick < 16) begin
            c.func = FUNC_INIT;
        end else begin
            c.func = ($urandom_range(0, 99) < wait_bias) ? FUNC_WAIT : FUNC_SIGNAL;
        end
        case ($urandom_range(0, 5))
            0, 1:    c.init_value = 16'($urandom_range(0, 3));
            2:       c.init_value = 16'(32'hFFFF - $urandom_range(0, 1));
            default: c.init_value = 16'($urandom_range(0, 16'hFFFF));
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // result checker: sampled at the edge that ends the result cycle
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_done !== 1'b0) begin
            if (result_q.size() == 0) begin
                $error("result with no command outstanding (o_done=%b)", o_done);
                n_errors++;
            end else begin
                e = result_q.pop_front();
                check_field("count_after",    e.count_after,    o_result.count_after);
                check_field("waiters_after",  16'(e.waiters_after),
                            16'(o_result.waiters_after));
                check_field("blocked",        16'(e.blocked),   16'(o_result.blocked));
                check_field("woken_valid",    16'(e.woken_valid),
                            16'(o_result.woken_valid));
                check_field("woken_process",  16'(e.woken_process),
                            16'(o_result.woken_process));
                check_field("queue_overflow", 16'(e.queue_overflow),
                            16'(o_result.queue_overflow));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("counting_semaphore_bank_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_result no_res;
        no_res = '0;
        for (int s = 0; s < NSEMS; s++) begin
            sem_cnt[s] = '0;
            q_head[s]  = 0;
            q_tail[s]  = 0;
            q_fill[s]  = 0;
        end

        //       op           sem  value     pid    typed count    wtr blk wv woken ovf
        add_row(FUNC_UNUSED,  3, 16'hFFFF, 8'hFF, 1, 16'h0000, 0, 0, 0, 8'h00, 0);
        add_row(FUNC_INIT,    0, 16'hFFFF, 8'h00, 1, 16'hFFFF, 0, 0, 0, 8'h00, 0);
        add_row(FUNC_SIGNAL,  0, 16'h0000, 8'h00, 1, 16'hFFFF, 0, 0, 0, 8'h00, 0);
        add_row(FUNC_WAIT,    0, 16'h0000, 8'hAA, 1, 16'hFFFE, 0, 0, 0, 8'h00, 0);
        add_row(FUNC_INIT,    1, 16'h0000, 8'h00, 1, 16'h0000, 0, 0, 0, 8'h00, 0);
        // zero count: fill the queue of sem 1 to the brim
        add_row(FUNC_WAIT,    1, 16'h0000, 8'h00, 1, 16'h0000, 1, 1, 0, 8'h00, 0);
        add_row(FUNC_WAIT,    1, 16'h0000, 8'hFF, 1, 16'h0000, 2, 1, 0, 8'h00, 0);
        add_row(FUNC_WAIT,    1, 16'h0000, 8'h11, 1, 16'h0000, 3, 1, 0, 8'h00, 0);
        add_row(FUNC_WAIT,    1, 16'h0000, 8'h22, 1, 16'h0000, 4, 1, 0, 8'h00, 0);
        add_row(FUNC_WAIT,    1, 16'h0000, 8'h33, 1, 16'h0000, 5, 1, 0, 8'h00, 0);
        add_row(FUNC_WAIT,    1, 16'h0000, 8'h44, 1, 16'h0000, 6, 1, 0, 8'h00, 0);
        add_row(FUNC_WAIT,    1, 16'h0000, 8'h55, 1, 16'h0000, 7, 1, 0, 8'h00, 0);
        add_row(FUNC_WAIT,    1, 16'h0000, 8'h66, 1, 16'h0000, 8, 1, 0, 8'h00, 0);
        // full queue drops the caller
        add_row(FUNC_WAIT,    1, 16'h0000, 8'h99, 1, 16'h0000, 8, 0, 0, 8'h00, 1);
        // init keeps the waiters queued
        add_row(FUNC_INIT,    1, 16'h0005, 8'h00, 1, 16'h0005, 8, 0, 0, 8'h00, 0);
        add_row(FUNC_SIGNAL,  1, 16'h0000, 8'h00, 1, 16'h0005, 7, 0, 1, 8'h00, 0);
        add_row(FUNC_SIGNAL,  1, 16'h0000, 8'h00, 1, 16'h0005, 6, 0, 1, 8'hFF, 0);
        add_row(FUNC_UNUSED,  1, 16'h1234, 8'h5A, 1, 16'h0005, 6, 0, 0, 8'h00, 0);
        // positive count takes a unit even with waiters present
        add_row(FUNC_WAIT,    1, 16'h0000, 8'h77, 1, 16'h0004, 6, 0, 0, 8'h00, 0);
        add_row(FUNC_INIT,   15, 16'h8000, 8'h00, 1, 16'h8000, 0, 0, 0, 8'h00, 0);
        add_row(FUNC_SIGNAL, 15, 16'h0000, 8'h00, 1, 16'h8001, 0, 0, 0, 8'h00, 0);
        add_row(FUNC_WAIT,   15, 16'h0000, 8'h00, 1, 16'h8000, 0, 0, 0, 8'h00, 0);
        // tail wraps to slot 0, then oldest waiter comes out
        add_row(FUNC_INIT,    1, 16'h0000, 8'h00, 0, 16'h0000, 0, 0, 0, 8'h00, 0);
        add_row(FUNC_WAIT,    1, 16'h0000, 8'hC3, 0, 16'h0000, 0, 0, 0, 8'h00, 0);
        add_row(FUNC_SIGNAL,  1, 16'h0000, 8'h00, 0, 16'h0000, 0, 0, 0, 8'h00, 0);

        // hold synchronous reset, then release it
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[k]) issue(dir_tbl[k].cmd, dir_tbl[k].typed, dir_tbl[k].res);

        // random run in phases: each phase picks a new hot set and leans
        // toward either waits (queues fill) or signals (queues drain)
        for (int k = 0; k < RANDOM_CMDS; k++) begin
            if (k % 150 == 0) begin
                foreach (hot_sems[h]) hot_sems[h] = 4'($urandom_range(0, NSEMS - 1));
                wait_bias = (k % 300 == 0) ? 65 : 35;
            end
            issue(random_cmd(), 1'b0, no_res);
        end
        i_start <= 1'b0;

        // drain, then idle to catch stray results
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d commands: %0d waits queued, %0d wake-ups, %0d overflows,",
                 n_cmds, n_queued, n_woken, n_dropped);
        $display("%0d signals held at max count, %0d cycles", n_pegged, cycle_cnt);
        if (n_errors == 0) begin
            $display("counting_semaphore_bank_tb: PASS");
        end else begin
            $display("counting_semaphore_bank_tb: FAIL");
        end
        $finish;
    end

endmodule
